/* sv/gcbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gcbs_pkg
// Shared types and constants for the grid cell binary search block.
// ----------------------------------------------------------------------------
package gcbs_pkg;

  localparam int MAX_SIDE_DEF = 16;
  localparam int GRID_SIDE_W  = 5;
  localparam int COORD_W      = 32;
  localparam int INDEX_W      = 8;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                       command;
    logic        [INDEX_W-1:0]  cell_index;
    logic signed [COORD_W-1:0]  bound_x_min;
    logic signed [COORD_W-1:0]  bound_x_max;
    logic signed [COORD_W-1:0]  bound_y_min;
    logic signed [COORD_W-1:0]  bound_y_max;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] found_index;
  } out_item_t;

  // One table entry: both axes of one cell
  typedef struct packed {
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] x_max;
    logic signed [COORD_W-1:0] y_min;
    logic signed [COORD_W-1:0] y_max;
  } cell_bounds_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_HOLD
  } state_t;

endpackage
`default_nettype wire

/* sv/gcbs_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gcbs_table
// Cell bounds table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gcbs_table import gcbs_pkg::*; #(
  parameter int DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF,
  parameter int AW    = 8
) (
  input  wire logic         clk,
  input  wire logic         wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire cell_bounds_t wr_data,
  input  wire logic         rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output cell_bounds_t      rd_data
);

  cell_bounds_t mem [DEPTH];
  cell_bounds_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* sv/grid_cell_binary_search.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grid_cell_binary_search
// Locates the cell of a square grid that holds a point, by a binary search
// run independently on the x and y cell coordinates over a bounds table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in_     | input     | in_valid / in_ready   | in_data  (in_item_t)
//  out_    | output    | out_valid / out_ready | out_data (out_item_t)
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_data (grid_side)
//
//  A load item writes the table at its accepting edge and gives no item.
//  A query item runs each probe as a table read (S_PROBE), then a compare (S_CMP); each
//  probe halves every axis still searching, so at most floor(log2(side))+1
//  probes: the result item is registered when the last compare ends (or from
//  S_HOLD if the output is stalled), and in_ready returns together with it.
//  Reset clears control state and sets grid_side to 1; the table is not
//  cleared. A stalled output holds the finished search until out_ready.
// ----------------------------------------------------------------------------
module grid_cell_binary_search import gcbs_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [GRID_SIDE_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // side width, and a signed coordinate width that holds -1 .. side
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CW    = SW + 1;
  localparam int PW    = 2 * SW;

  state_t state_r, state_nxt;

  logic [GRID_SIDE_W-1:0] grid_side_r;
  logic [SW-1:0]          side_r, side_nxt;
  logic signed [CW-1:0]   lx_r, lx_nxt, rx_r, rx_nxt;
  logic signed [CW-1:0]   ly_r, ly_nxt, ry_r, ry_nxt;
  logic [SW-1:0]          mx_r, mx_nxt, my_r, my_nxt;
  logic                   fx_r, fx_nxt, fy_r, fy_nxt;
  logic [AW-1:0]          cell_r, cell_nxt;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic                   tbl_wr_en;
  logic [AW-1:0]          tbl_wr_addr;
  cell_bounds_t           tbl_wr_data;
  logic                   tbl_rd_en;
  cell_bounds_t           tbl_rd_data;

  logic                   in_acc;
  logic [SW-1:0]          side_eff;
  logic signed [CW:0]     sum_x, sum_y;
  logic [SW-1:0]          inv_x, inv_y;
  logic [PW-1:0]          row_base;
  logic                   go_on;
  logic                   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Clamp the side register into 1 .. MAX_SIDE
  always_comb begin
    if (grid_side_r == '0) begin
      side_eff = SW'(1);
    end else if (32'(grid_side_r) > MAX_SIDE) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(grid_side_r);
    end
  end

  // Loads go straight into the table on acceptance
  assign tbl_wr_en   = in_acc && (in_data.command == CMD_LOAD)
                       && (32'(in_data.cell_index) < DEPTH);
  assign tbl_wr_addr = AW'(in_data.cell_index);
  assign tbl_wr_data = '{x_min: in_data.bound_x_min, x_max: in_data.bound_x_max,
                         y_min: in_data.bound_y_min, y_max: in_data.bound_y_max};
  assign tbl_rd_en   = (state_r == S_PROBE);

  gcbs_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (cell_nxt),
    .rd_data (tbl_rd_data)
  );

  // Midpoints: both ends are non-negative while the search runs
  assign sum_x = (CW+1)'(lx_r) + (CW+1)'(rx_r);
  assign sum_y = (CW+1)'(ly_r) + (CW+1)'(ry_r);

  // Reverse row-major index of the probed cell
  assign inv_x    = side_r - SW'(1) - mx_nxt;
  assign inv_y    = side_r - SW'(1) - my_nxt;
  assign row_base = PW'(inv_y) * PW'(side_r);

  always_comb begin
    state_nxt     = state_r;
    side_nxt      = side_r;
    lx_nxt        = lx_r;
    rx_nxt        = rx_r;
    ly_nxt        = ly_r;
    ry_nxt        = ry_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    cell_nxt      = cell_r;
    go_on         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        // Start a query with the full range on both axes
        if (in_acc && (in_data.command == CMD_QUERY)) begin
          side_nxt  = side_eff;
          lx_nxt    = '0;
          ly_nxt    = '0;
          rx_nxt    = CW'(side_eff) - CW'(1);
          ry_nxt    = CW'(side_eff) - CW'(1);
          mx_nxt    = '0;
          my_nxt    = '0;
          fx_nxt    = 1'b0;
          fy_nxt    = 1'b0;
          state_nxt = S_PROBE;
        end
      end

      S_PROBE: begin
        // Move the unfrozen axes to their midpoints and read that cell
        if (!fx_r) begin
          mx_nxt = SW'(sum_x >>> 1);
        end
        if (!fy_r) begin
          my_nxt = SW'(sum_y >>> 1);
        end
        cell_nxt  = AW'(row_base + PW'(inv_x));
        state_nxt = S_CMP;
      end

      S_CMP: begin
        // x axis: step right, step left or freeze
        if (tbl_rd_data.x_max < px_r) begin
          lx_nxt = CW'(mx_r) + CW'(1);
        end else if (tbl_rd_data.x_min > px_r) begin
          rx_nxt = CW'(mx_r) - CW'(1);
        end else begin
          fx_nxt = 1'b1;
        end
        // y axis likewise
        if (tbl_rd_data.y_max < py_r) begin
          ly_nxt = CW'(my_r) + CW'(1);
        end else if (tbl_rd_data.y_min > py_r) begin
          ry_nxt = CW'(my_r) - CW'(1);
        end else begin
          fy_nxt = 1'b1;
        end

        go_on = (lx_nxt <= rx_nxt) && (ly_nxt <= ry_nxt) && !(fx_nxt && fy_nxt);
        if (go_on) begin
          state_nxt = S_PROBE;
        end else if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.found       = fx_nxt && fy_nxt;
          out_data_nxt.found_index = (fx_nxt && fy_nxt) ? INDEX_W'(cell_r) : '0;
          state_nxt                = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end

      S_HOLD: begin
        // Wait for the output register to free up
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.found       = fx_r && fy_r;
          out_data_nxt.found_index = (fx_r && fy_r) ? INDEX_W'(cell_r) : '0;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      grid_side_r <= GRID_SIDE_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        grid_side_r <= cfg_data;
      end
    end
  end

  // Search payload
  always_ff @(posedge clk) begin
    side_r     <= side_nxt;
    lx_r       <= lx_nxt;
    rx_r       <= rx_nxt;
    ly_r       <= ly_nxt;
    ry_r       <= ry_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      px_r <= in_data.point_x;
      py_r <= in_data.point_y;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.command == CMD_QUERY) |=> state_r == S_PROBE)
    else $error("query did not start a probe");

  a_probe_reads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |=> state_r == S_CMP)
    else $error("probe not followed by compare");

  a_mid_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> (mx_r < side_r) && (my_r < side_r))
    else $error("probed cell outside the grid");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.found || (out_data_r.found_index == '0))
    else $error("index set on a miss");

  a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.command == CMD_LOAD) && !out_valid_r |=> !out_valid_r)
    else $error("load produced an item");

endmodule
`default_nettype wire
